// ===== rtl/min_max_frame_normalizer_unit_assert.svh =====
// Assertion macros shared by the normalizer RTL.
`ifndef MIN_MAX_FRAME_NORMALIZER_UNIT_ASSERT_SVH
`define MIN_MAX_FRAME_NORMALIZER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked property, disabled while reset is active.
`define MMFN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked property, checked during reset too.
`define MMFN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MMFN_ASSERT(lbl, clk, rstn, prop, msg)
`define MMFN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/mmfn_pkg.sv =====
// Shared constants and types of the min-max frame normalizer.
package mmfn_pkg;

  localparam int unsigned NORM_BITS  = 17;
  localparam int unsigned QUOT_BITS  = 17;
  localparam int unsigned STEP_BITS  = $clog2(QUOT_BITS);
  localparam int unsigned NORM_BYTES = (NORM_BITS + 7) / 8;

  localparam logic [NORM_BITS-1:0] NORM_HALF = 17'd32768;
  localparam logic [NORM_BITS-1:0] NORM_ONE  = 17'd65536;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/min_max_frame_normalizer_unit.sv =====
// Min-max frame normalizer: sample buffer, running min/max, drain sequencer.
// Load transaction: taken in the idle state, which it does not leave, so ready stays high.
// Drain transaction: buffer read, prepare, divide in the radix-2 divider, capture, then output
// once the output register is free; a flat frame skips the divider and yields one half.
// The block takes one transaction at a time: ready stays low until a drain is back in idle.
// rst_ni clears control state at once; buffer contents stay undefined until loaded.
`include "min_max_frame_normalizer_unit_assert.svh"

module min_max_frame_normalizer_unit #(
  parameter int unsigned MAX_SAMPLES = 16384,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [SAMPLE_BITS-1:0] sample, zero filled to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata_i,
  // [0] opcode
  input  logic                                  s_axis_tuser_i,
  input  logic                                  s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [16:0] normalized, zero filled to whole bytes
  output logic [mmfn_pkg::NORM_BYTES*8-1:0]     m_axis_tdata_o,
  // [0] overflowed
  output logic                                  m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned NW = mmfn_pkg::NORM_BYTES * 8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;

  logic [2:0]                       state_q, state_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [CW-1:0]                    drain_q, drain_d;
  logic signed [SAMPLE_BITS-1:0]    min_q, min_d;
  logic signed [SAMPLE_BITS-1:0]    max_q, max_d;
  logic                             complete_q, complete_d;
  logic                             ovf_q, ovf_d;
  logic [mmfn_pkg::NORM_BITS-1:0]   res_q, res_d;
  logic                             out_valid_q, out_valid_d;
  logic [mmfn_pkg::NORM_BITS-1:0]   out_norm_q;
  logic                             out_last_q;
  logic                             out_ovf_q;

  logic signed [SAMPLE_BITS-1:0]    mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0]    rd_data_q;

  logic                             s_fire;
  logic                             is_load;
  logic                             pending;
  logic [CW-1:0]                    eff_count;
  logic                             store_en;
  logic signed [SAMPLE_BITS-1:0]    sample;
  logic signed [SAMPLE_BITS:0]      offs_wide;
  logic signed [SAMPLE_BITS:0]      range_wide;
  logic                             flat;
  logic                             div_start;
  logic                             put_now;
  mmfn_pkg::div_status_t            div_st;
  logic [mmfn_pkg::QUOT_BITS-1:0]   div_quot;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load   = (s_axis_tuser_i == mmfn_pkg::OP_LOAD);
  assign sample    = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign pending   = complete_q && (drain_q < count_q);
  // A load after a completed frame starts over from an empty buffer.
  assign eff_count = complete_q ? '0 : count_q;
  assign store_en  = s_fire && is_load && (eff_count < CW'(MAX_SAMPLES));

  assign offs_wide  = {rd_data_q[SAMPLE_BITS-1], rd_data_q} - {min_q[SAMPLE_BITS-1], min_q};
  assign range_wide = {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};
  assign flat       = (max_q == min_q);
  assign div_start  = (state_q == ST_CALC) && !flat;
  assign put_now    = (state_q == ST_PUT) && (!out_valid_q || m_axis_tready_i);

  mmfn_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .offs_i  (offs_wide[SAMPLE_BITS-1:0]),
    .range_i (range_wide[SAMPLE_BITS-1:0]),
    .status_o(div_st),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drain_d     = drain_q;
    min_d       = min_q;
    max_d       = max_q;
    complete_d  = complete_q;
    ovf_d       = ovf_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (is_load) begin
            ovf_d = complete_q ? 1'b0 : ovf_q;
            if (store_en) begin
              count_d = eff_count + 1'b1;
              if (eff_count == '0) begin
                min_d = sample;
                max_d = sample;
              end else begin
                if (sample < min_q) min_d = sample;
                if (sample > max_q) max_d = sample;
              end
            end else begin
              count_d = eff_count;
              ovf_d   = 1'b1;
            end
            if (complete_q || s_axis_tlast_i) begin
              drain_d = '0;
            end
            complete_d = s_axis_tlast_i;
          end else if (pending) begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (flat) begin
          res_d   = mmfn_pkg::NORM_HALF;
          state_d = ST_PUT;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          res_d   = div_quot;
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (put_now) begin
          out_valid_d = 1'b1;
          drain_d     = drain_q + 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drain_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      complete_q  <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drain_q     <= drain_d;
      min_q       <= min_d;
      max_q       <= max_d;
      complete_q  <= complete_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (put_now) begin
      out_norm_q <= res_q;
      out_last_q <= ((drain_q + 1'b1) == count_q);
      out_ovf_q  <= ovf_q;
    end
  end

  // Sample buffer: one write port for loads, one registered read for drains.
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[eff_count[IW-1:0]] <= sample;
    end
    if (state_q == ST_RD) begin
      rd_data_q <= mem[drain_q[IW-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(NW - mmfn_pkg::NORM_BITS){1'b0}}, out_norm_q};
  assign m_axis_tuser_o  = out_ovf_q;
  assign m_axis_tlast_o  = out_last_q;

  `MMFN_ASSERT(a_div_done_in_div, clk_i, rst_ni, (div_st.busy || div_st.done) |-> (state_q == ST_DIV), "divider active outside the divide state")
  `MMFN_ASSERT(a_drain_starts_read, clk_i, rst_ni, (s_fire && !is_load && pending) |=> (state_q == ST_RD), "pending drain did not start a buffer read")
  `MMFN_ASSERT(a_norm_in_range, clk_i, rst_ni, m_axis_tvalid_o |-> (out_norm_q <= mmfn_pkg::NORM_ONE), "normalized result above 1.0")
  `MMFN_ASSERT(a_count_bounded, clk_i, rst_ni, (count_q <= CW'(MAX_SAMPLES)) && (drain_q <= count_q), "sample count or drain index out of bounds")

endmodule

// ===== rtl/mmfn_div.sv =====
// Radix-2 restoring divider: floor(offs * 2^16 / range), one quotient bit per cycle.
module mmfn_div #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [SAMPLE_BITS-1:0]             offs_i,
  input  logic [SAMPLE_BITS-1:0]             range_i,
  output mmfn_pkg::div_status_t              status_o,
  output logic [mmfn_pkg::QUOT_BITS-1:0]     quot_o
);

  logic [SAMPLE_BITS-1:0]             rem_q, rem_d;
  logic [SAMPLE_BITS-1:0]             range_q;
  logic [mmfn_pkg::QUOT_BITS-1:0]     quot_q, quot_d;
  logic [mmfn_pkg::STEP_BITS-1:0]     step_q, step_d;
  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [SAMPLE_BITS:0]               trial;
  logic                               fits;

  always_comb begin
    // First step compares offs itself; later steps shift the remainder first.
    if (step_q == '0) begin
      trial = {1'b0, rem_q};
    end else begin
      trial = {rem_q, 1'b0};
    end
    fits = (trial >= {1'b0, range_q});
  end

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = offs_i;
      quot_d = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = trial[SAMPLE_BITS-1:0] - range_q;
      end else begin
        rem_d = trial[SAMPLE_BITS-1:0];
      end
      quot_d = {quot_q[mmfn_pkg::QUOT_BITS-2:0], fits};
      if (step_q == mmfn_pkg::STEP_BITS'(mmfn_pkg::QUOT_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      range_q <= range_i;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule
